### rtl/rast_pkg.sv
// ----------------------------------------------------------------------------
// rast_pkg: shared types and constants for the range assign / range sum tree
// Holds the function codes, the controller state type and the command and
// status structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rast_pkg;

  localparam int unsigned SumW  = 43;
  localparam int unsigned OutW  = 42;
  localparam int unsigned ValW  = 32;
  localparam int unsigned IdxW  = 10;

  typedef enum logic {
    FUNC_ASSIGN = 1'b0,
    FUNC_QUERY  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VISIT,
    ST_READ,
    ST_EVAL,
    ST_PUSH,
    ST_MUL,
    ST_OUT
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear_step;
    logic load;
    logic visit;
    logic read;
    logic eval;
    logic push;
    logic mul;
    logic present;
    logic out_take;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_done;
    logic is_query;
    logic stack_empty;
    logic full_cover;
    logic out_busy;
  } sts_t;

endpackage

### rtl/range_assign_range_sum_tree_unit.sv
// ----------------------------------------------------------------------------
// range_assign_range_sum_tree_unit: lazy segment tree, range assign / sum
// Top level: joins the walk sequencer and the tree datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o): one transfer carries func_i,
//   left_index_i, right_index_i and assign_value_i. func 0 assigns the value
//   to every element of the inclusive range; func 1 queries the range sum.
//   Output channel (out_valid_o / out_ready_i): one transfer of range_sum_o
//   per query, none per assign. An empty range queries as 0.
//   Walk: an item walks the tree from an explicit stack; each stack frame
//   steps through pop, memory read, evaluate and write. An item walks one
//   frame for the full span and up to about 4*log2(LEAVES) frames for a
//   query, up to about 6*log2(LEAVES) for an assign (recombine frames
//   included).
//   Throughput: one item at a time; in_ready_o is high only between walks.
//   The result sits in its own output register, so the next item is taken
//   while it waits.
//   Reset: a clearing pass zeroes the node memories; in_ready_o stays low
//   until it ends.
//   Stall: a result holds on the output until out_ready_i takes it; a later
//   query holds at the end of its walk until the output register is free.
// ----------------------------------------------------------------------------
module range_assign_range_sum_tree_unit #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      func_i,
  input  logic [rast_pkg::IdxW-1:0] left_index_i,
  input  logic [rast_pkg::IdxW-1:0] right_index_i,
  input  logic [rast_pkg::ValW-1:0] assign_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rast_pkg::OutW-1:0] range_sum_o
);

  rast_pkg::cmd_t cmd;
  rast_pkg::sts_t sts;

  rast_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rast_dp #(.Leaves(LEAVES)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .func_i         (func_i),
    .left_index_i   (left_index_i),
    .right_index_i  (right_index_i),
    .assign_value_i (assign_value_i),
    .out_valid_o    (out_valid_o),
    .range_sum_o    (range_sum_o)
  );

`ifndef NO_ASSERTIONS
  // a presented result carries known data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown(range_sum_o))
    else $error("unknown result data");

  // a result holds until transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(range_sum_o))
    else $error("result dropped under stall");
`endif

endmodule

### rtl/rast_ctrl.sv
// ----------------------------------------------------------------------------
// rast_ctrl: sequencer for the tree walk
// Steps the datapath through clear, node visit, push and combine phases.
// ----------------------------------------------------------------------------
module rast_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  input  rast_pkg::sts_t sts_i,
  output rast_pkg::cmd_t cmd_o
);

  rast_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rast_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cmd_o.out_take = out_ready_i;
    unique case (state_q)
      rast_pkg::ST_CLEAR: begin
        if (sts_i.clear_done) state_d = rast_pkg::ST_IDLE;
        else cmd_o.clear_step = 1'b1;
      end
      rast_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = rast_pkg::ST_VISIT;
        end
      end
      rast_pkg::ST_VISIT: begin
        // pops next frame; empty stack ends the walk
        if (sts_i.stack_empty) begin
          state_d = sts_i.is_query ? rast_pkg::ST_OUT : rast_pkg::ST_IDLE;
        end else begin
          cmd_o.visit = 1'b1;
          state_d = rast_pkg::ST_READ;
        end
      end
      rast_pkg::ST_READ: begin
        cmd_o.read = 1'b1;
        state_d = rast_pkg::ST_EVAL;
      end
      rast_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.full_cover) state_d = rast_pkg::ST_MUL;
        else state_d = rast_pkg::ST_PUSH;
      end
      rast_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = rast_pkg::ST_VISIT;
      end
      rast_pkg::ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d = rast_pkg::ST_VISIT;
      end
      rast_pkg::ST_OUT: begin
        // wait for the output register to free up
        if (!sts_i.out_busy) begin
          cmd_o.present = 1'b1;
          state_d = rast_pkg::ST_IDLE;
        end
      end
    endcase
  end

endmodule

### rtl/rast_dp.sv
// ----------------------------------------------------------------------------
// rast_dp: tree storage and walk datapath
// Node memories, an explicit walk stack, the lazy push and the sum combine.
// Stack frames are either a visit of a node or a recombine of a node.
// ----------------------------------------------------------------------------
module rast_dp #(
  parameter int unsigned Leaves = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rast_pkg::cmd_t            cmd_i,
  output rast_pkg::sts_t            sts_o,
  input  logic                      func_i,
  input  logic [rast_pkg::IdxW-1:0] left_index_i,
  input  logic [rast_pkg::IdxW-1:0] right_index_i,
  input  logic [rast_pkg::ValW-1:0] assign_value_i,
  output logic                      out_valid_o,
  output logic [rast_pkg::OutW-1:0] range_sum_o
);

  localparam int unsigned LW    = (Leaves > 1) ? $clog2(Leaves) : 1;
  localparam int unsigned PW    = LW + 1;               // position width
  localparam int unsigned NW    = $clog2(4 * Leaves);   // node index width
  localparam int unsigned Nodes = 4 * Leaves;
  localparam int unsigned SD    = 2 * LW + 4;           // stack depth
  localparam int unsigned SPW   = $clog2(SD + 1);
  localparam logic [PW-1:0] LastPos = PW'(Leaves - 1);

  typedef struct packed {
    logic          recomb;
    logic [NW-1:0] node;
    logic [PW-1:0] lo;
    logic [PW-1:0] hi;
    logic [PW-1:0] l;
    logic [PW-1:0] r;
  } frame_t;

  // Node memories; a clearing pass zeroes them after reset.
  logic [rast_pkg::SumW-1:0] sum_mem [Nodes];
  logic [rast_pkg::ValW-1:0] pv_mem  [Nodes];
  logic                      pf_mem  [Nodes];

  frame_t            stack_q [SD];
  logic [SPW-1:0]    sp_q;
  logic [NW-1:0]     clr_q;
  logic              clr_done_q;
  logic              query_q;
  logic [rast_pkg::ValW-1:0] val_q;
  frame_t            cur_q;
  logic [rast_pkg::SumW-1:0] acc_q;
  logic [rast_pkg::SumW-1:0] rsum_q;
  logic [rast_pkg::ValW-1:0] rpv_q;
  logic              rpf_q;
  logic              out_valid_q;
  logic [rast_pkg::OutW-1:0] out_q;

  logic [PW-1:0] l_in, r_in, mid;
  logic          empty_in;
  logic [NW-1:0] lc, rc;
  logic [PW:0]   span;

  assign l_in = PW'(left_index_i);
  assign r_in = (32'(right_index_i) > Leaves - 1) ? LastPos : PW'(right_index_i);
  assign empty_in = (32'(left_index_i) >= Leaves) || (r_in < l_in);
  assign mid  = cur_q.lo + ((cur_q.hi - cur_q.lo) >> 1);
  assign lc   = {cur_q.node[NW-2:0], 1'b0};
  assign rc   = {cur_q.node[NW-2:0], 1'b1};
  assign span = {1'b0, cur_q.hi} - {1'b0, cur_q.lo} + 1'b1;

  logic full_cover, is_leaf;
  assign full_cover = (cur_q.l == cur_q.lo) && (cur_q.r == cur_q.hi);
  assign is_leaf    = (cur_q.lo == cur_q.hi);

  // value*span products, each 32 x (PW+1) bits, registered before use
  logic [rast_pkg::SumW-1:0] prod_q;
  logic [rast_pkg::SumW-1:0] half_lo_q, half_hi_q;
  logic [PW:0] span_l, span_r;
  logic [rast_pkg::ValW+PW:0] prod_w, half_lo_w, half_hi_w;
  assign span_l    = {1'b0, mid} - {1'b0, cur_q.lo} + 1'b1;
  assign span_r    = {1'b0, cur_q.hi} - {1'b0, mid};
  assign prod_w    = val_q * span;
  assign half_lo_w = rpv_q * span_l;
  assign half_hi_w = rpv_q * span_r;

  // right child sum read for recombine; the left one lands in rsum_q
  logic [rast_pkg::SumW-1:0] cs_r_q;
  logic                      up_phase_q;

  assign sts_o.clear_done  = clr_done_q;
  assign sts_o.is_query    = query_q;
  assign sts_o.stack_empty = (sp_q == '0);
  assign sts_o.full_cover  = full_cover;
  assign sts_o.out_busy    = out_valid_q && !cmd_i.out_take;
  assign out_valid_o       = out_valid_q;
  assign range_sum_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      clr_q       <= '0;
      clr_done_q  <= 1'b0;
      query_q     <= 1'b0;
      out_valid_q <= 1'b0;
      up_phase_q  <= 1'b0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == NW'(Nodes - 1)) clr_done_q <= 1'b1;
      end
      if (cmd_i.present) out_valid_q <= 1'b1;
      else if (out_valid_q && cmd_i.out_take) out_valid_q <= 1'b0;
      if (cmd_i.load) begin
        query_q <= (func_i == rast_pkg::FUNC_QUERY);
        sp_q    <= empty_in ? '0 : SPW'(1);
      end
      if (cmd_i.visit) begin
        sp_q       <= sp_q - 1'b1;
        up_phase_q <= stack_q[sp_q-1'b1].recomb;
      end
      if (cmd_i.eval && !full_cover && !up_phase_q) begin
        sp_q <= sp_q + SPW'(2) + ((!query_q) ? SPW'(1) : SPW'(0)) -
                ((cur_q.l > mid) ? SPW'(1) : SPW'(0)) -
                ((cur_q.r <= mid) ? SPW'(1) : SPW'(0));
      end
    end
  end

  // payload and memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      sum_mem[clr_q] <= '0;
      pv_mem[clr_q]  <= '0;
      pf_mem[clr_q]  <= 1'b0;
    end
    if (cmd_i.load) begin
      val_q <= assign_value_i;
      acc_q <= '0;
      stack_q[0] <= '{recomb: 1'b0, node: NW'(1), lo: '0, hi: LastPos,
                      l: l_in, r: r_in};
    end
    if (cmd_i.visit) begin
      cur_q <= stack_q[sp_q-1'b1];
    end
    if (cmd_i.read) begin
      rsum_q <= sum_mem[up_phase_q ? lc : cur_q.node];
      cs_r_q <= sum_mem[rc];
      rpv_q  <= pv_mem[cur_q.node];
      rpf_q  <= pf_mem[cur_q.node];
      prod_q <= prod_w[rast_pkg::SumW-1:0];
    end
    if (cmd_i.eval && up_phase_q) begin
      sum_mem[cur_q.node] <= rsum_q + cs_r_q;
    end else if (cmd_i.eval && !full_cover) begin
      // pending value moves to the children in the push cycle
      pf_mem[cur_q.node] <= 1'b0;
      half_lo_q <= half_lo_w[rast_pkg::SumW-1:0];
      half_hi_q <= half_hi_w[rast_pkg::SumW-1:0];
      // push frames: recombine (assign only) below children so it runs last
      if (!query_q) begin
        stack_q[sp_q] <= '{recomb: 1'b1, node: cur_q.node, lo: cur_q.lo, hi: cur_q.hi,
                           l: cur_q.l, r: cur_q.r};
      end
      if (cur_q.l <= mid) begin
        stack_q[sp_q + ((!query_q) ? SPW'(1) : SPW'(0))] <=
          '{recomb: 1'b0, node: lc, lo: cur_q.lo, hi: mid, l: cur_q.l,
            r: (cur_q.r < mid) ? cur_q.r : mid};
      end
      if (cur_q.r > mid) begin
        stack_q[sp_q + ((!query_q) ? SPW'(1) : SPW'(0)) +
                ((cur_q.l <= mid) ? SPW'(1) : SPW'(0))] <=
          '{recomb: 1'b0, node: rc, lo: mid + 1'b1, hi: cur_q.hi,
            l: (cur_q.l > mid + 1'b1) ? cur_q.l : mid + 1'b1, r: cur_q.r};
      end
    end
    if (cmd_i.mul) begin
      if (query_q) begin
        acc_q <= acc_q + rsum_q;
      end else begin
        sum_mem[cur_q.node] <= prod_q;
        pv_mem[cur_q.node]  <= val_q;
        pf_mem[cur_q.node]  <= 1'b1;
      end
    end
    if (cmd_i.push && !up_phase_q && rpf_q && !is_leaf) begin
      sum_mem[lc] <= half_lo_q;
      sum_mem[rc] <= half_hi_q;
      pv_mem[lc]  <= rpv_q;
      pv_mem[rc]  <= rpv_q;
      pf_mem[lc]  <= 1'b1;
      pf_mem[rc]  <= 1'b1;
    end
    if (cmd_i.present) begin
      out_q <= acc_q[rast_pkg::OutW-1:0];
    end
  end

endmodule

### verif/range_assign_range_sum_tree_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_assign_range_sum_tree_unit_test: self-checking bench for the tree
// Drives random and directed range assigns and range-sum queries through the
// valid/ready channels. A flat array model predicts each query sum, and the
// monitor compares every output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module range_assign_range_sum_tree_unit_test;

  localparam int unsigned LEAVES    = 1024;
  localparam int unsigned CYCLE_CAP = 2000000;

  typedef struct packed {
    rast_pkg::func_e               func;
    logic [rast_pkg::IdxW-1:0]     left_idx;
    logic [rast_pkg::IdxW-1:0]     right_idx;
    logic [rast_pkg::ValW-1:0]     value;
  } op_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic                      func_i = 1'b0;
  logic [rast_pkg::IdxW-1:0] left_index_i = '0;
  logic [rast_pkg::IdxW-1:0] right_index_i = '0;
  logic [rast_pkg::ValW-1:0] assign_value_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [rast_pkg::OutW-1:0] range_sum_o;

  // Flat image of the element array; the tree must agree with it.
  logic [rast_pkg::ValW-1:0] elem_mirror [LEAVES];
  op_t                       op_queue [$];
  logic [rast_pkg::OutW-1:0] sum_queue [$];
  int unsigned     err_count = 0;
  int unsigned     cycle_count = 0;
  bit              stim_done = 1'b0;
  // No idling while this is set; toggled by the stimulus block.
  bit              burst_mode = 1'b0;

  range_assign_range_sum_tree_unit #(.LEAVES(LEAVES)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .left_index_i,
    .right_index_i, .assign_value_i, .out_valid_o, .out_ready_i, .range_sum_o
  );

  always #5 clk_i = ~clk_i;

  // Apply an accepted op to the mirror; a query queues its expected sum.
  function automatic void apply_op(op_t op);
    int unsigned lo, hi;
    logic [rast_pkg::SumW-1:0] acc;
    lo = op.left_idx;
    hi = (op.right_idx >= LEAVES) ? LEAVES - 1 : op.right_idx;
    acc = '0;
    // Empty range: left past the end or right below left touches nothing.
    if (lo < LEAVES && lo <= hi) begin
      for (int unsigned i = lo; i <= hi; i++) begin
        if (op.func == rast_pkg::FUNC_ASSIGN) elem_mirror[i] = op.value;
        else acc += elem_mirror[i];
      end
    end
    if (op.func == rast_pkg::FUNC_QUERY) sum_queue = {sum_queue, acc[rast_pkg::OutW-1:0]};
  endfunction

  function automatic op_t make_op(rast_pkg::func_e f, int unsigned l, int unsigned r,
                                  logic [rast_pkg::ValW-1:0] v);
    op_t op;
    op.func = f;
    op.left_idx = rast_pkg::IdxW'(l);
    op.right_idx = rast_pkg::IdxW'(r);
    op.value = v;
    return op;
  endfunction

  function automatic void add_op(op_t op);
    op_queue = {op_queue, op};
  endfunction

  // Driver: holds valid and payload until the transfer happens.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        apply_op(op_queue.pop_front());
      end
      if (!in_valid_i || in_ready_o) begin
        // Offer the next op unless idling this cycle.
        if (op_queue.size() > 0 && (burst_mode || $urandom_range(99) >= 35)) begin
          in_valid_i     <= 1'b1;
          func_i         <= op_queue[0].func;
          left_index_i   <= op_queue[0].left_idx;
          right_index_i  <= op_queue[0].right_idx;
          assign_value_i <= op_queue[0].value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure and the result check.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      out_ready_i <= burst_mode || ($urandom_range(99) >= 35);
      if (out_valid_o && out_ready_i) begin
        if (sum_queue.size() == 0) begin
          $error("range_sum: unexpected transfer, actual %0d", range_sum_o);
          err_count++;
        end else begin
          logic [rast_pkg::OutW-1:0] exp_sum;
          exp_sum = sum_queue.pop_front();
          if (range_sum_o !== exp_sum) begin
            $error("range_sum: expected %0d, actual %0d", exp_sum, range_sum_o);
            err_count++;
          end
        end
      end
    end
  end

  // Random op: mostly short ranges, some wide, some empty (right below left).
  function automatic op_t rand_op();
    int unsigned l, r, sel;
    logic [rast_pkg::ValW-1:0] v;
    sel = $urandom_range(99);
    l = $urandom_range(LEAVES - 1);
    if (sel < 60) r = l + $urandom_range(40);
    else if (sel < 85) r = $urandom_range(LEAVES - 1);
    else r = $urandom_range(1023);
    if (r > 1023) r = 1023;
    case ($urandom_range(3))
      0: v = '0;
      1: v = '1;
      default: v = $urandom();
    endcase
    return make_op(rast_pkg::func_e'($urandom_range(1)), l, r, v);
  endfunction

  initial begin
    for (int i = 0; i < LEAVES; i++) elem_mirror[i] = '0;
    // Directed: cleared store, full span, extremes, zero assign, empty ranges.
    add_op(make_op(rast_pkg::FUNC_QUERY, 0, 1023, 0));
    add_op(make_op(rast_pkg::FUNC_ASSIGN, 0, 1023, 32'hFFFF_FFFF));
    add_op(make_op(rast_pkg::FUNC_QUERY, 0, 1023, 0));
    add_op(make_op(rast_pkg::FUNC_QUERY, 1023, 1023, 0));
    add_op(make_op(rast_pkg::FUNC_ASSIGN, 100, 600, 0));
    add_op(make_op(rast_pkg::FUNC_QUERY, 0, 1023, 0));
    add_op(make_op(rast_pkg::FUNC_QUERY, 99, 101, 32'hFFFF_FFFF));
    add_op(make_op(rast_pkg::FUNC_ASSIGN, 10, 5, 32'h1234));
    add_op(make_op(rast_pkg::FUNC_QUERY, 10, 5, 0));
    add_op(make_op(rast_pkg::FUNC_QUERY, 0, 0, 0));
    add_op(make_op(rast_pkg::FUNC_ASSIGN, 0, 0, 32'h5555_AAAA));
    add_op(make_op(rast_pkg::FUNC_ASSIGN, 1023, 1023, 32'hAAAA_5555));
    add_op(make_op(rast_pkg::FUNC_QUERY, 0, 1, 0));
    add_op(make_op(rast_pkg::FUNC_QUERY, 1022, 1023, 0));
    add_op(make_op(rast_pkg::FUNC_ASSIGN, 511, 512, 7));
    add_op(make_op(rast_pkg::FUNC_QUERY, 510, 513, 0));
    add_op(make_op(rast_pkg::FUNC_QUERY, 512, 511, 0));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 450; i++) add_op(rand_op());
    // Middle stretch of the run without idling on either side.
    wait (op_queue.size() < 300);
    @(posedge clk_i);
    burst_mode <= 1'b1;
    wait (op_queue.size() < 200);
    @(posedge clk_i);
    burst_mode <= 1'b0;
    wait (op_queue.size() == 0);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done && sum_queue.size() == 0);
    repeat (500) @(posedge clk_i);
    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog: the run is far shorter than this even under full stalls.
  initial begin
    wait (cycle_count >= CYCLE_CAP);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### files.f
rtl/rast_pkg.sv
rtl/rast_ctrl.sv
rtl/rast_dp.sv
rtl/range_assign_range_sum_tree_unit.sv
verif/range_assign_range_sum_tree_unit_test.sv
